// ===== src/assert_macros.svh =====
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== src/lwkd_pkg.sv =====
// shared constants and sequencer state type for the distinct-window block
`timescale 1ns / 1ps

package lwkd_pkg;

    localparam int CFG_W         = 4;
    localparam int VAL_IN_W      = 32;
    localparam int OUT_W         = 24;
    localparam int DEFAULT_LIMIT = 2;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_PLACE  = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_EVICT  = 7'b0010000,
        S_DROP   = 7'b0100000,
        S_FINISH = 7'b1000000
    } seq_state_t;

endpackage

// ===== src/longest_window_k_distinct.sv =====
// Longest run holding at most K distinct values, one sequence at a time.
//
// Input channel (in_valid/in_ready): one beat carries value and last. A beat
// with last high closes the sequence and yields one beat on the output channel
// (out_valid/out_ready) carrying longest_length; other beats yield nothing.
// cfg_we/cfg_wdata writes distinct_limit (reset 2, 0 acts as 1, values above
// MAX_LIMIT act as MAX_LIMIT); write it only while the block is idle.
// Each beat passes through these steps in order: accept, one pass over the
// MAX_LIMIT+1 slots to find a match and the first free slot, then placement,
// limit check and length update. Each eviction adds a further pass over the
// slots to find the oldest slot; one eviction per beat is the usual case once
// the limit is reached. A last beat then passes the finish step, which loads
// the result register.
// in_ready is high only between beats. The result sits in an output register;
// the next beat is accepted while it waits, and only a following last beat
// holds in its final cycle until the receiver takes the earlier result.
// Reset clears the slot table, the window state and the result valid flag and
// sets the limit to 2; the table is cleared again after every last beat.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module longest_window_k_distinct #(
    parameter int MAX_LIMIT   = 8,
    parameter int POS_WIDTH   = 24,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lwkd_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [lwkd_pkg::VAL_IN_W-1:0] value,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lwkd_pkg::OUT_W-1:0]          longest_length
);

    import lwkd_pkg::*;

    localparam int SLOTS = MAX_LIMIT + 1;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int KEY_W = (VALUE_WIDTH < VAL_IN_W) ? VALUE_WIDTH : VAL_IN_W;
    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
    localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(SLOTS - 1);

    seq_state_t state_reg, state_next;

    logic [CFG_W-1:0]     limit_reg, limit_next;
    logic [SLOTS-1:0]     valid_reg, valid_next;
    logic [KEY_W-1:0]     slot_value_reg [SLOTS];
    logic [POS_WIDTH-1:0] slot_pos_reg [SLOTS];

    logic [KEY_W-1:0]     key_reg, key_next;
    logic                 last_reg, last_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     hit_reg, hit_next;
    logic                 hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]     free_reg, free_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     old_reg, old_next;
    logic                 old_found_reg, old_found_next;
    logic [POS_WIDTH-1:0] old_pos_reg, old_pos_next;

    logic [POS_WIDTH-1:0] position_reg, position_next;
    logic [POS_WIDTH-1:0] window_start_reg, window_start_next;
    logic [POS_WIDTH-1:0] best_reg, best_next;
    logic                 reached_reg, reached_next;

    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_len_reg, out_len_next;

    logic                 val_we;
    logic                 pos_we;
    logic [IDX_W-1:0]     place_idx;
    logic [CNT_W-1:0]     lim_eff;
    logic [KEY_W-1:0]     rd_value;
    logic [POS_WIDTH-1:0] rd_pos;
    logic [POS_WIDTH-1:0] start_cand;
    logic [POS_WIDTH:0]   run_len_wide;
    logic [POS_WIDTH-1:0] run_len;
    logic [CNT_W-1:0]     count_placed;

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign longest_length = out_len_reg;

    assign rd_value  = slot_value_reg[idx_reg];
    assign rd_pos    = slot_pos_reg[idx_reg];
    assign place_idx = hit_found_reg ? hit_reg : free_reg;

    // effective limit clamped to 1..MAX_LIMIT
    always_comb
    begin
        if (limit_reg == '0)
        begin
            lim_eff = CNT_W'(1);
        end
        else if (int'(limit_reg) > MAX_LIMIT)
        begin
            lim_eff = CNT_W'(MAX_LIMIT);
        end
        else
        begin
            lim_eff = CNT_W'(limit_reg);
        end
    end

    assign start_cand   = (old_pos_reg == POS_MAX) ? POS_MAX : old_pos_reg + 1'b1;
    assign count_placed = count_reg + CNT_W'(!hit_found_reg);

    // run length of the window ending at the current position
    always_comb
    begin
        run_len_wide = {1'b0, position_reg} - {1'b0, window_start_reg} + 1'b1;
        if (position_reg < window_start_reg)
        begin
            run_len = '0;
        end
        else if (run_len_wide[POS_WIDTH])
        begin
            run_len = POS_MAX;
        end
        else
        begin
            run_len = run_len_wide[POS_WIDTH-1:0];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        limit_next        = cfg_we ? cfg_wdata : limit_reg;
        valid_next        = valid_reg;
        key_next          = key_reg;
        last_next         = last_reg;
        idx_next          = idx_reg;
        count_next        = count_reg;
        hit_next          = hit_reg;
        hit_found_next    = hit_found_reg;
        free_next         = free_reg;
        free_found_next   = free_found_reg;
        old_next          = old_reg;
        old_found_next    = old_found_reg;
        old_pos_next      = old_pos_reg;
        position_next     = position_reg;
        window_start_next = window_start_reg;
        best_next         = best_reg;
        reached_next      = reached_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_len_next      = out_len_reg;
        val_we            = 1'b0;
        pos_we            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next        = value[KEY_W-1:0];
                    last_next       = last;
                    idx_next        = '0;
                    count_next      = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (valid_reg[idx_reg])
                begin
                    count_next = count_reg + 1'b1;
                    if (!hit_found_reg && rd_value == key_reg)
                    begin
                        hit_next       = idx_reg;
                        hit_found_next = 1'b1;
                    end
                end
                else if (!free_found_reg)
                begin
                    free_next       = idx_reg;
                    free_found_next = 1'b1;
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_PLACE:
            begin
                // a new value takes the first free slot
                pos_we     = 1'b1;
                val_we     = !hit_found_reg;
                hit_next   = place_idx;
                count_next = count_placed;
                valid_next[place_idx] = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (count_reg > lim_eff)
                begin
                    idx_next       = '0;
                    old_found_next = 1'b0;
                    state_next     = S_EVICT;
                end
                else
                begin
                    if (count_reg == lim_eff)
                    begin
                        reached_next = 1'b1;
                    end
                    if (run_len > best_reg)
                    begin
                        best_next = run_len;
                    end
                    if (position_reg != POS_MAX)
                    begin
                        position_next = position_reg + 1'b1;
                    end
                    state_next = last_reg ? S_FINISH : S_IDLE;
                end
            end
            S_EVICT:
            begin
                if (valid_reg[idx_reg] && idx_reg != hit_reg &&
                    (!old_found_reg || rd_pos < old_pos_reg))
                begin
                    old_next       = idx_reg;
                    old_pos_next   = rd_pos;
                    old_found_next = 1'b1;
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DROP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DROP:
            begin
                if (old_found_reg)
                begin
                    valid_next[old_reg] = 1'b0;
                    count_next          = count_reg - 1'b1;
                    if (start_cand > window_start_reg)
                    begin
                        window_start_next = start_cand;
                    end
                end
                state_next = S_CHECK;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    out_len_next      = OUT_W'(reached_reg ? best_reg : position_reg);
                    valid_next        = '0;
                    position_next     = '0;
                    window_start_next = '0;
                    best_next         = '0;
                    reached_next      = 1'b0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            limit_reg        <= CFG_W'(DEFAULT_LIMIT);
            valid_reg        <= '0;
            position_reg     <= '0;
            window_start_reg <= '0;
            best_reg         <= '0;
            reached_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            idx_reg          <= '0;
            count_reg        <= '0;
            hit_found_reg    <= 1'b0;
            free_found_reg   <= 1'b0;
            old_found_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            limit_reg        <= limit_next;
            valid_reg        <= valid_next;
            position_reg     <= position_next;
            window_start_reg <= window_start_next;
            best_reg         <= best_next;
            reached_reg      <= reached_next;
            out_valid_reg    <= out_valid_next;
            idx_reg          <= idx_next;
            count_reg        <= count_next;
            hit_found_reg    <= hit_found_next;
            free_found_reg   <= free_found_next;
            old_found_reg    <= old_found_next;
        end
    end

    // item and scan payload
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        last_reg    <= last_next;
        hit_reg     <= hit_next;
        free_reg    <= free_next;
        old_reg     <= old_next;
        old_pos_reg <= old_pos_next;
        out_len_reg <= out_len_next;
    end

    // slot table
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            slot_value_reg[place_idx] <= key_reg;
        end
        if (pos_we)
        begin
            slot_pos_reg[place_idx] <= position_reg;
        end
    end

    `ASSERT_IMPLIES(a_idle_fill, clk, rst_n, state_reg == S_IDLE,
        $countones(valid_reg) <= MAX_LIMIT, "slot table overfull between beats")
    `ASSERT_IMPLIES(a_start_le_pos, clk, rst_n, state_reg == S_IDLE,
        window_start_reg <= position_reg, "window start beyond position")
    `ASSERT_IMPLIES(a_best_le_pos, clk, rst_n, state_reg == S_IDLE,
        best_reg <= position_reg, "best length beyond position")
    `ASSERT_NEXT(a_result_from_finish, clk, rst_n, state_reg != S_FINISH && !out_valid_reg,
        !out_valid_reg, "result raised outside the finish step")

endmodule
